[src/clle_pkg.sv]
`default_nettype none

package clle_pkg;

   localparam int NODES_DEFAULT      = 1024;
   localparam int DATA_WIDTH_DEFAULT = 32;

   localparam int KindW   = 2;
   localparam int PosW    = 10;
   localparam int ValueW  = 32;
   localparam int StatusW = 2;
   localparam int LenW    = 10;

   typedef logic [KindW-1:0]   kind_type;
   typedef logic [StatusW-1:0] status_type;

   localparam kind_type KIND_INSERT = 2'd0;
   localparam kind_type KIND_APPEND = 2'd1;
   localparam kind_type KIND_DELETE = 2'd2;
   localparam kind_type KIND_READ   = 2'd3;

   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_RANGE = 2'd1;
   localparam status_type ST_FULL  = 2'd2;

   typedef struct packed {
      kind_type          kind;
      logic [PosW-1:0]   position;
      logic [ValueW-1:0] value;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic [ValueW-1:0] read_value;
      logic [LenW-1:0]   list_length;
   } rsp_type;

endpackage

`default_nettype wire

[src/clle_channels.sv]
`default_nettype none

interface clle_req_if;
   import clle_pkg::*;

   logic    valid;
   logic    ready;
   req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface clle_rsp_if;
   import clle_pkg::*;

   logic    valid;
   logic    ready;
   rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

[src/cursor_linked_list_engine_unit.sv]
// Positional list engine over a fixed node store. Each request (insert at a
// 1-based position, append, delete at a position, read at a position) walks
// the next-links from the list head one node per cycle through the link
// memory's single read port, following position - 1 links (the list length
// for append) before it links, unlinks or reads. Rejected requests skip the
// walk and go straight to the response. Values sit in a second memory. After
// reset a clearing pass over every link entry builds the free chain in the
// link memory, and no request is taken until it ends. A response register
// lets the next request be accepted while the previous response waits for
// rsp_ch.ready.
`default_nettype none

module cursor_linked_list_engine_unit #(
   parameter int NODES      = clle_pkg::NODES_DEFAULT,
   parameter int DATA_WIDTH = clle_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   clle_req_if.sink    req_ch,
   clle_rsp_if.source  rsp_ch
);
   import clle_pkg::*;

   localparam int IW   = $clog2(NODES);
   localparam int CMPW = ((IW > PosW) ? IW : PosW) + 1;

   localparam logic [IW-1:0] HEAD      = IW'(NODES - 1);
   localparam logic [IW-1:0] LAST_FREE = IW'(NODES - 2);
   localparam logic [IW-1:0] NIL       = '0;

   localparam logic [3:0] S_INIT   = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_ALLOC  = 4'd2;
   localparam logic [3:0] S_WALK   = 4'd3;
   localparam logic [3:0] S_LINK   = 4'd4;
   localparam logic [3:0] S_UNLINK = 4'd5;
   localparam logic [3:0] S_FREE   = 4'd6;
   localparam logic [3:0] S_FETCH  = 4'd7;
   localparam logic [3:0] S_DONE   = 4'd8;

   logic [IW-1:0]         link_mem [NODES];
   logic [DATA_WIDTH-1:0] val_mem  [NODES];

   logic [3:0]            state_ff, state_in;
   logic [IW-1:0]         free_ff, free_in;
   logic [IW-1:0]         count_ff, count_in;
   logic [IW-1:0]         cur_ff, cur_in;
   logic [IW-1:0]         left_ff, left_in;
   logic [IW-1:0]         node_ff, node_in;   // fresh node on insert, removed node on delete
   logic [IW-1:0]         aux_ff, aux_in;     // successor on insert, predecessor on delete
   kind_type              kind_ff, kind_in;
   logic [DATA_WIDTH-1:0] value_ff, value_in;
   status_type            status_ff, status_in;
   logic [ValueW-1:0]     rdval_ff, rdval_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic [IW-1:0]         link_rd_ff;
   logic [DATA_WIDTH-1:0] val_rd_ff;
   logic [IW-1:0]         link_addr;
   logic                  link_we;
   logic [IW-1:0]         link_waddr;
   logic [IW-1:0]         link_wdata;
   logic                  val_we;
   logic [IW-1:0]         val_raddr;

   logic                  req_fire;
   logic [CMPW-1:0]       pos_w;
   logic [CMPW-1:0]       cnt_w;

   assign req_ch.ready   = (state_ff == S_IDLE);
   assign req_fire       = req_ch.valid && (state_ff == S_IDLE);
   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_ff;

   assign pos_w = CMPW'(req_ch.payload.position);
   assign cnt_w = CMPW'(count_ff);

   always_comb begin
      state_in     = state_ff;
      free_in      = free_ff;
      count_in     = count_ff;
      cur_in       = cur_ff;
      left_in      = left_ff;
      node_in      = node_ff;
      aux_in       = aux_ff;
      kind_in      = kind_ff;
      value_in     = value_ff;
      status_in    = status_ff;
      rdval_in     = rdval_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_in       = rsp_ff;
      link_addr    = cur_ff;
      link_we      = 1'b0;
      link_waddr   = NIL;
      link_wdata   = NIL;
      val_we       = 1'b0;
      val_raddr    = NIL;

      unique case (state_ff)
         S_INIT: begin
            // build the free chain 1 -> 2 -> ... -> NODES-2 -> end; head ends empty
            link_we    = 1'b1;
            link_waddr = cur_ff;
            link_wdata = (cur_ff < LAST_FREE) ? IW'(cur_ff + 1'b1) : NIL;
            if (cur_ff == HEAD) begin
               state_in = S_IDLE;
            end else begin
               cur_in = IW'(cur_ff + 1'b1);
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               kind_in   = req_ch.payload.kind;
               value_in  = DATA_WIDTH'(req_ch.payload.value);
               status_in = ST_OK;
               rdval_in  = '0;
               unique case (req_ch.payload.kind)
                  KIND_INSERT: begin
                     if (pos_w == '0 || pos_w > cnt_w + CMPW'(1)) begin
                        status_in = ST_RANGE;
                        state_in  = S_DONE;
                     end else if (free_ff == NIL) begin
                        status_in = ST_FULL;
                        state_in  = S_DONE;
                     end else begin
                        link_addr = free_ff;
                        left_in   = IW'(pos_w - CMPW'(1));
                        state_in  = S_ALLOC;
                     end
                  end
                  KIND_APPEND: begin
                     if (free_ff == NIL) begin
                        status_in = ST_FULL;
                        state_in  = S_DONE;
                     end else begin
                        link_addr = free_ff;
                        left_in   = count_ff;
                        state_in  = S_ALLOC;
                     end
                  end
                  KIND_DELETE, KIND_READ: begin
                     if (pos_w == '0 || pos_w > cnt_w) begin
                        status_in = ST_RANGE;
                        state_in  = S_DONE;
                     end else begin
                        link_addr = HEAD;
                        cur_in    = HEAD;
                        left_in   = IW'(pos_w - CMPW'(1));
                        state_in  = S_WALK;
                     end
                  end
               endcase
            end
         end
         S_ALLOC: begin
            // link_rd_ff holds the node after the fresh one on the free chain
            node_in   = free_ff;
            free_in   = link_rd_ff;
            val_we    = 1'b1;
            link_addr = HEAD;
            cur_in    = HEAD;
            state_in  = S_WALK;
         end
         S_WALK: begin
            // link_rd_ff is always the successor of cur_ff here
            if (left_ff != NIL) begin
               cur_in    = link_rd_ff;
               link_addr = link_rd_ff;
               left_in   = IW'(left_ff - 1'b1);
            end else begin
               unique case (kind_ff)
                  KIND_INSERT, KIND_APPEND: begin
                     link_we    = 1'b1;
                     link_waddr = cur_ff;
                     link_wdata = node_ff;
                     aux_in     = link_rd_ff;
                     state_in   = S_LINK;
                  end
                  KIND_DELETE: begin
                     aux_in    = cur_ff;
                     node_in   = link_rd_ff;
                     link_addr = link_rd_ff;
                     state_in  = S_UNLINK;
                  end
                  KIND_READ: begin
                     val_raddr = link_rd_ff;
                     state_in  = S_FETCH;
                  end
               endcase
            end
         end
         S_LINK: begin
            link_we    = 1'b1;
            link_waddr = node_ff;
            link_wdata = aux_ff;
            count_in   = IW'(count_ff + 1'b1);
            state_in   = S_DONE;
         end
         S_UNLINK: begin
            link_we    = 1'b1;
            link_waddr = aux_ff;
            link_wdata = link_rd_ff;
            state_in   = S_FREE;
         end
         S_FREE: begin
            link_we    = 1'b1;
            link_waddr = node_ff;
            link_wdata = free_ff;
            free_in    = node_ff;
            count_in   = IW'(count_ff - 1'b1);
            state_in   = S_DONE;
         end
         S_FETCH: begin
            rdval_in = ValueW'(val_rd_ff);
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in       = 1'b1;
               rsp_in.status      = status_ff;
               rsp_in.read_value  = rdval_ff;
               rsp_in.list_length = LenW'(count_ff);
               state_in           = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         free_ff      <= IW'(1);
         count_ff     <= NIL;
         cur_ff       <= NIL;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         free_ff      <= free_in;
         count_ff     <= count_in;
         cur_ff       <= cur_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff   <= left_in;
      node_ff   <= node_in;
      aux_ff    <= aux_in;
      kind_ff   <= kind_in;
      value_ff  <= value_in;
      status_ff <= status_in;
      rdval_ff  <= rdval_in;
      rsp_ff    <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_waddr] <= link_wdata;
      end
      link_rd_ff <= link_mem[link_addr];
   end

   always_ff @(posedge clock) begin
      if (val_we) begin
         val_mem[free_ff] <= value_ff;
      end
      val_rd_ff <= val_mem[val_raddr];
   end

   // free chain is empty exactly when the list holds NODES-2 elements
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> ((free_ff == NIL) == (count_ff == LAST_FREE)))
      else $error("free chain and element count disagree");

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= LAST_FREE)
      else $error("element count beyond capacity");

   // the list head is never linked to from any node
   assert property (@(posedge clock) disable iff (reset)
      (link_we && state_ff != S_INIT) |-> (link_wdata != HEAD))
      else $error("link written toward list head");

   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff != S_IDLE))
      else $error("accepted request did not start");

endmodule

`default_nettype wire
